/* sv/register_stack_vm_execute_unit_defines.svh */
// ---------------------------------------------------------------------------
// Register-stack VM execute unit: assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef REGISTER_STACK_VM_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_STACK_VM_EXECUTE_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is high
`define RSVM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset
`define RSVM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rsvm_pkg.sv */
// ---------------------------------------------------------------------------
// Register-stack VM execute unit: package
// Beat types, opcodes, sequencer states and shared ALU types.
// ---------------------------------------------------------------------------
package rsvm_pkg;

   // Default sizes
   localparam int NUM_REGS_DEF      = 16;
   localparam int DATA_DEPTH_DEF    = 1024;
   localparam int STACK_DEPTH_DEF   = 64;
   localparam int PROGRAM_DEPTH_DEF = 1024;

   // Field widths
   localparam int OPC_W  = 5;
   localparam int REG_W  = 8;
   localparam int WORD_W = 32;
   localparam int PLEN_W = 11;
   localparam logic [PLEN_W-1:0] PLEN_RESET = 11'd1024;

   // Opcodes
   localparam logic [OPC_W-1:0] OP_HALT = 5'd0;
   localparam logic [OPC_W-1:0] OP_LDI  = 5'd1;
   localparam logic [OPC_W-1:0] OP_MOV  = 5'd2;
   localparam logic [OPC_W-1:0] OP_ADD  = 5'd3;
   localparam logic [OPC_W-1:0] OP_SUB  = 5'd4;
   localparam logic [OPC_W-1:0] OP_MUL  = 5'd5;
   localparam logic [OPC_W-1:0] OP_DIV  = 5'd6;
   localparam logic [OPC_W-1:0] OP_JMP  = 5'd7;
   localparam logic [OPC_W-1:0] OP_JZ   = 5'd8;
   localparam logic [OPC_W-1:0] OP_JNZ  = 5'd9;
   localparam logic [OPC_W-1:0] OP_PUSH = 5'd10;
   localparam logic [OPC_W-1:0] OP_POP  = 5'd11;
   localparam logic [OPC_W-1:0] OP_CALL = 5'd12;
   localparam logic [OPC_W-1:0] OP_RET  = 5'd13;
   localparam logic [OPC_W-1:0] OP_PRT  = 5'd14;
   localparam logic [OPC_W-1:0] OP_LD   = 5'd15;
   localparam logic [OPC_W-1:0] OP_ST   = 5'd16;

   // Input beat
   typedef struct packed {
      logic [OPC_W-1:0]         opcode;
      logic [REG_W-1:0]         reg_a;
      logic [REG_W-1:0]         reg_b;
      logic signed [WORD_W-1:0] immediate;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [PLEN_W-1:0]        next_pc;
      logic                     stopped;
      logic                     print_valid;
      logic signed [WORD_W-1:0] print_value;
      logic                     stack_overflow;
   } rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_EXEC,
      ST_ALU,
      ST_DONE
   } state_type;

   // Shared ALU
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } alu_rsp_type;

endpackage

/* sv/rsvm_alu.sv */
// ---------------------------------------------------------------------------
// Register-stack VM execute unit: shared arithmetic unit
// Add/sub results are registered straight from the request; shift-add multiply
// and restoring divide take one bit a cycle. Divide truncates toward zero on signed operands.
// ---------------------------------------------------------------------------
module rsvm_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  rsvm_pkg::alu_req_type req,
   output rsvm_pkg::alu_rsp_type rsp
);

   localparam int W = rsvm_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   rsvm_pkg::alu_op_type op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         x_ff, x_in;
   logic [W-1:0]         y_ff, y_in;
   logic                 neg_ff, neg_in;
   logic [W-1:0]         res_ff, res_in;
   logic [W:0]           rem_shift;
   logic [W:0]           rem_diff;

   // One step of the selected operation
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      rem_shift = {acc_ff, y_ff[W-1]};
      rem_diff  = rem_shift - {1'b0, x_ff};
      if (req.start) begin
         op_in  = req.op;
         cnt_in = '0;
         acc_in = '0;
         case (req.op)
            rsvm_pkg::ALU_ADD: begin
               res_in  = req.a + req.b;
               done_in = 1'b1;
            end
            rsvm_pkg::ALU_SUB: begin
               res_in  = req.a - req.b;
               done_in = 1'b1;
            end
            rsvm_pkg::ALU_MUL: begin
               x_in    = req.a;
               y_in    = req.b;
               busy_in = 1'b1;
            end
            rsvm_pkg::ALU_DIV: begin
               // work on magnitudes, fix the sign at the end
               y_in    = req.a[W-1] ? (W'(0) - req.a) : req.a;
               x_in    = req.b[W-1] ? (W'(0) - req.b) : req.b;
               neg_in  = req.a[W-1] ^ req.b[W-1];
               busy_in = 1'b1;
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == rsvm_pkg::ALU_MUL) begin
            acc_in = acc_ff + (y_ff[0] ? x_ff : W'(0));
            x_in   = {x_ff[W-2:0], 1'b0};
            y_in   = {1'b0, y_ff[W-1:1]};
         end else begin
            // restoring divide: remainder in acc, quotient shifts into y
            if (!rem_diff[W]) begin
               acc_in = rem_diff[W-1:0];
               y_in   = {y_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_shift[W-1:0];
               y_in   = {y_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == rsvm_pkg::ALU_MUL) begin
               res_in = acc_in;
            end else begin
               res_in = neg_ff ? (W'(0) - y_in) : y_in;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

/* sv/register_stack_vm_execute_unit.sv */
// ---------------------------------------------------------------------------
// Register-stack VM execute unit
// Executes one instruction beat per request and returns the next pc, status,
// debug print value and stack overflow flag.
// ---------------------------------------------------------------------------
// Sequence: accept in idle, register file read of A then B, execute, then the
// result state; add/sub/mul/div first wait in the shared arithmetic unit.
// A beat arriving while stopped goes straight to the result state.
// One instruction at a time: a new beat is taken only after the last result.
// Reset: synchronous; a clearing pass then zeroes the data memory, one word a
// cycle, with req_ready low. CSR writes are taken always.
module register_stack_vm_execute_unit #(
   parameter int NUM_REGS      = rsvm_pkg::NUM_REGS_DEF,
   parameter int DATA_DEPTH    = rsvm_pkg::DATA_DEPTH_DEF,
   parameter int STACK_DEPTH   = rsvm_pkg::STACK_DEPTH_DEF,
   parameter int PROGRAM_DEPTH = rsvm_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rsvm_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsvm_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [rsvm_pkg::PLEN_W-1:0] csr_wr_data
);

   localparam int W      = rsvm_pkg::WORD_W;
   localparam int PLEN_W = rsvm_pkg::PLEN_W;
   localparam int RI_W   = $clog2(NUM_REGS);
   localparam int DA_W   = $clog2(DATA_DEPTH);
   localparam int SI_W   = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int PC_W   = $clog2(PROGRAM_DEPTH + 1);
   localparam int LIM_W  = (PC_W > PLEN_W) ? PC_W : PLEN_W;

   // Sequencer and architectural state
   rsvm_pkg::state_type state_ff, state_in;
   rsvm_pkg::req_type   item_ff, item_in;
   logic [W-1:0]        a_ff, a_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic                halt_ff, halt_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [DA_W-1:0]     clr_ff, clr_in;
   logic                pvalid_ff, pvalid_in;
   logic [W-1:0]        pv_ff, pv_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsvm_pkg::rsp_type   rsp_ff, rsp_in;

   // Register file: memory with one read and one write port, valid bits
   logic [W-1:0]        rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic [W-1:0]        rf_q_ff;
   logic                rf_qv_ff;
   logic                rf_re, rf_we;
   logic [RI_W-1:0]     rf_raddr, rf_waddr;
   logic [W-1:0]        rf_wdata, rf_rd;

   // Data memory
   logic [W-1:0]        dm_mem [DATA_DEPTH];
   logic [W-1:0]        dm_q_ff;
   logic                dm_re, dm_we;
   logic [DA_W-1:0]     dm_waddr;
   logic [W-1:0]        dm_wdata;

   // Stack memory
   logic [W-1:0]        stk_mem [STACK_DEPTH];
   logic [W-1:0]        stk_q_ff;
   logic                stk_re, stk_we;
   logic [W-1:0]        stk_wdata;

   // Shared arithmetic unit
   rsvm_pkg::alu_req_type alu_req;
   rsvm_pkg::alu_rsp_type alu_rsp;

   // Decode helpers
   logic [W-1:0]     imm;
   logic             a_ok, ab_ok, addr_ok;
   logic [RI_W-1:0]  ra_idx, rb_idx;
   logic [LIM_W-1:0] lim;
   logic             stopped_now;
   logic             rsp_free;
   logic [PC_W-1:0]  pc_inc;
   logic             stk_full, stk_empty;

   function automatic logic [PC_W-1:0] clamp_target(input logic [W-1:0] t);
      if (t[W-1] || (t > W'(PROGRAM_DEPTH))) begin
         return PC_W'(PROGRAM_DEPTH);
      end
      return t[PC_W-1:0];
   endfunction

   rsvm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // Decode
   always_comb begin
      imm         = item_ff.immediate;
      a_ok        = item_ff.reg_a < rsvm_pkg::REG_W'(NUM_REGS);
      ab_ok       = a_ok && (item_ff.reg_b < rsvm_pkg::REG_W'(NUM_REGS));
      addr_ok     = !imm[W-1] && (imm < W'(DATA_DEPTH));
      ra_idx      = item_ff.reg_a[RI_W-1:0];
      rb_idx      = item_ff.reg_b[RI_W-1:0];
      rf_rd       = rf_qv_ff ? rf_q_ff : '0;
      lim         = (LIM_W'(plen_ff) < LIM_W'(PROGRAM_DEPTH)) ? LIM_W'(plen_ff)
                                                             : LIM_W'(PROGRAM_DEPTH);
      stopped_now = halt_ff || (LIM_W'(pc_ff) >= lim);
      rsp_free    = !rsp_valid_ff || rsp_ready;
      pc_inc      = pc_ff + 1'b1;
      stk_full    = cnt_ff >= CNT_W'(STACK_DEPTH);
      stk_empty   = cnt_ff == '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsvm_pkg::ST_CLEAR: begin
            if (clr_ff == DA_W'(DATA_DEPTH - 1)) state_in = rsvm_pkg::ST_IDLE;
         end
         rsvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = stopped_now ? rsvm_pkg::ST_DONE : rsvm_pkg::ST_READ_A;
            end
         end
         rsvm_pkg::ST_READ_A: state_in = rsvm_pkg::ST_READ_B;
         rsvm_pkg::ST_READ_B: state_in = rsvm_pkg::ST_EXEC;
         rsvm_pkg::ST_EXEC: begin
            state_in = alu_req.start ? rsvm_pkg::ST_ALU : rsvm_pkg::ST_DONE;
         end
         rsvm_pkg::ST_ALU: begin
            if (alu_rsp.done) state_in = rsvm_pkg::ST_DONE;
         end
         rsvm_pkg::ST_DONE: begin
            if (rsp_free) state_in = rsvm_pkg::ST_IDLE;
         end
         default: state_in = rsvm_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      item_in      = item_ff;
      a_in         = a_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      cnt_in       = cnt_ff;
      plen_in      = csr_wr_en ? csr_wr_data : plen_ff;
      clr_in       = clr_ff;
      pvalid_in    = pvalid_ff;
      pv_in        = pv_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      rf_re        = 1'b0;
      rf_raddr     = rb_idx;
      rf_we        = 1'b0;
      rf_waddr     = ra_idx;
      rf_wdata     = imm;
      dm_re        = 1'b0;
      dm_we        = 1'b0;
      dm_waddr     = imm[DA_W-1:0];
      dm_wdata     = a_ff;
      stk_re       = 1'b0;
      stk_we       = 1'b0;
      stk_wdata    = a_ff;
      alu_req      = '0;
      alu_req.a    = a_ff;
      alu_req.b    = rf_rd;
      alu_req.op   = rsvm_pkg::ALU_ADD;

      case (state_ff)
         rsvm_pkg::ST_CLEAR: begin
            dm_we    = 1'b1;
            dm_waddr = clr_ff;
            dm_wdata = '0;
            clr_in   = clr_ff + 1'b1;
         end
         rsvm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in   = req_data;
               pvalid_in = 1'b0;
               pv_in     = '0;
               ovf_in    = 1'b0;
            end
         end
         rsvm_pkg::ST_READ_A: begin
            // operand A, memory word and stack top all read here
            rf_re    = 1'b1;
            rf_raddr = ra_idx;
            dm_re    = 1'b1;
            stk_re   = 1'b1;
         end
         rsvm_pkg::ST_READ_B: begin
            rf_re = 1'b1;
            a_in  = rf_rd;
         end
         rsvm_pkg::ST_EXEC: begin
            pc_in = pc_inc;
            case (item_ff.opcode)
               rsvm_pkg::OP_HALT: halt_in = 1'b1;
               rsvm_pkg::OP_LDI: rf_we = a_ok;
               rsvm_pkg::OP_MOV: begin
                  rf_we    = ab_ok;
                  rf_wdata = rf_rd;
               end
               rsvm_pkg::OP_ADD: begin
                  alu_req.start = ab_ok;
                  alu_req.op    = rsvm_pkg::ALU_ADD;
               end
               rsvm_pkg::OP_SUB: begin
                  alu_req.start = ab_ok;
                  alu_req.op    = rsvm_pkg::ALU_SUB;
               end
               rsvm_pkg::OP_MUL: begin
                  alu_req.start = ab_ok;
                  alu_req.op    = rsvm_pkg::ALU_MUL;
               end
               rsvm_pkg::OP_DIV: begin
                  // divide by zero leaves the destination alone
                  alu_req.start = ab_ok && (rf_rd != '0);
                  alu_req.op    = rsvm_pkg::ALU_DIV;
               end
               rsvm_pkg::OP_JMP: pc_in = clamp_target(imm);
               rsvm_pkg::OP_JZ: begin
                  if (a_ok && (a_ff == '0)) pc_in = clamp_target(imm);
               end
               rsvm_pkg::OP_JNZ: begin
                  if (a_ok && (a_ff != '0)) pc_in = clamp_target(imm);
               end
               rsvm_pkg::OP_PUSH: begin
                  if (a_ok) begin
                     if (stk_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        stk_we = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               rsvm_pkg::OP_POP: begin
                  if (a_ok && !stk_empty) begin
                     rf_we    = 1'b1;
                     rf_wdata = stk_q_ff;
                     cnt_in   = cnt_ff - 1'b1;
                  end
               end
               rsvm_pkg::OP_CALL: begin
                  // return address dropped on a full stack, jump still taken
                  if (stk_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     stk_we    = 1'b1;
                     stk_wdata = W'(pc_inc);
                     cnt_in    = cnt_ff + 1'b1;
                  end
                  pc_in = clamp_target(imm);
               end
               rsvm_pkg::OP_RET: begin
                  if (!stk_empty) begin
                     pc_in  = clamp_target(stk_q_ff);
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
               rsvm_pkg::OP_PRT: begin
                  if (a_ok) begin
                     pvalid_in = 1'b1;
                     pv_in     = a_ff;
                  end
               end
               rsvm_pkg::OP_LD: begin
                  rf_we    = a_ok && addr_ok;
                  rf_wdata = dm_q_ff;
               end
               rsvm_pkg::OP_ST: dm_we = a_ok && addr_ok;
               default: ;
            endcase
         end
         rsvm_pkg::ST_ALU: begin
            rf_we    = alu_rsp.done;
            rf_wdata = alu_rsp.result;
         end
         rsvm_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.next_pc        = PLEN_W'(pc_ff);
               rsp_in.stopped        = stopped_now;
               rsp_in.print_valid    = pvalid_ff;
               rsp_in.print_value    = pv_ff;
               rsp_in.stack_overflow = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsvm_pkg::ST_CLEAR;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         cnt_ff       <= '0;
         plen_ff      <= rsvm_pkg::PLEN_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rf_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         cnt_ff       <= cnt_in;
         plen_ff      <= plen_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we) rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      a_ff      <= a_in;
      pvalid_ff <= pvalid_in;
      pv_ff     <= pv_in;
      ovf_ff    <= ovf_in;
      rsp_ff    <= rsp_in;
   end

   // Register file memory
   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
      if (rf_re) begin
         rf_q_ff  <= rf_mem[rf_raddr];
         rf_qv_ff <= rf_vld_ff[rf_raddr];
      end
   end

   // Data memory
   always_ff @(posedge clock) begin
      if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
      if (dm_re) dm_q_ff <= dm_mem[imm[DA_W-1:0]];
   end

   // Stack memory: write at count, read the top entry
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[cnt_ff[SI_W-1:0]] <= stk_wdata;
      if (stk_re) stk_q_ff <= stk_mem[SI_W'(cnt_ff - 1'b1)];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/rsvm_checker.sv */
// ---------------------------------------------------------------------------
// Register-stack VM execute unit: port checker
// Watches the top-level ports and is bound to every instance of the unit.
// ---------------------------------------------------------------------------
`include "register_stack_vm_execute_unit_defines.svh"

module rsvm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsvm_pkg::rsp_type rsp_data
);

   // A stalled result beat holds
   `RSVM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // Print value is zero unless a print happened
   `RSVM_ASSERT(a_print_zero, clock, reset, rsp_valid && !rsp_data.print_valid |-> rsp_data.print_value == 0, "print value without print")

   // One instruction never both prints and overflows
   `RSVM_ASSERT(a_one_flag, clock, reset, rsp_valid |-> !(rsp_data.print_valid && rsp_data.stack_overflow), "print and overflow together")

   // One instruction at a time: ready drops after an accepted beat
   `RSVM_ASSERT(a_one_beat, clock, reset, req_valid && req_ready |=> !req_ready, "ready held after accept")

   // After reset the unit clears memory before taking beats
   `RSVM_ASSERT_NR(a_reset_busy, clock, reset |=> !req_ready && !rsp_valid, "ready or valid right after reset")

endmodule

bind register_stack_vm_execute_unit rsvm_checker u_rsvm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
